// ===== hdl/rlst_pkg.sv =====
package rlst_pkg;

   // table geometry
   localparam int ENTRIES = 16;
   localparam int IDX_W   = $clog2(ENTRIES);
   localparam int CNT_W   = $clog2(ENTRIES + 1);

   // opcodes
   localparam logic [1:0] OP_ADD  = 2'd0;
   localparam logic [1:0] OP_DEL  = 2'd1;
   localparam logic [1:0] OP_READ = 2'd2;
   localparam logic [1:0] OP_NONE = 2'd3;

   // status codes
   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_RANGE  = 2'd1;
   localparam logic [1:0] ST_ABSENT = 2'd2;

   localparam logic [31:0] STAMP_MAX = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [63:0] lock_addr;
      logic [31:0] stack_ref;
      logic        is_write;
      logic        destroy;
      logic [3:0]  read_index;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [63:0] out_addr;
      logic [31:0] out_stack_ref;
      logic        out_is_write;
      logic [31:0] out_count;
      logic [31:0] out_stamp;
      logic [4:0]  set_size;
   } rsp_type;

   // one stored table entry
   typedef struct packed {
      logic [63:0] addr;
      logic [31:0] stack;
      logic        is_wr;
      logic [31:0] cnt;
      logic [31:0] stamp;
   } entry_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_UPDATE,
      S_APPEND,
      S_READ,
      S_RESP
   } state_type;

endpackage

// ===== hdl/refcounted_lock_set_table_top.sv =====
// add and delete: search every entry held, then update; an add that evicts also appends
// read in range: one memory read before the response; others go straight to the response
// a new request is taken in the cycle after the response register is loaded
// the single memory read port walks the table one entry per cycle during a search
// synchronous reset empties the table and zeroes the stamp counter; memory is not cleared
module refcounted_lock_set_table_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  rlst_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rlst_pkg::rsp_type rsp_data
);
   import rlst_pkg::*;

   // entry memory
   entry_type mem [ENTRIES];
   entry_type rd_data_ff;
   logic [IDX_W-1:0] rd_idx;
   logic wr_en;
   logic [IDX_W-1:0] wr_idx;
   entry_type wr_data;

   // control and work registers
   state_type state_ff, state_in;
   req_type req_ff, req_in;
   logic [CNT_W-1:0] iss_ff, iss_in;
   logic pend_ff, pend_in;
   logic [IDX_W-1:0] pidx_ff, pidx_in;
   logic found_ff, found_in;
   logic [IDX_W-1:0] pos_ff, pos_in;
   entry_type hit_ff, hit_in;
   logic [31:0] best_ff, best_in;
   logic [IDX_W-1:0] victim_ff, victim_in;
   entry_type last_ff, last_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [31:0] stamp_ff, stamp_in;
   rsp_type res_ff, res_in;
   rsp_type rsp_ff, rsp_in;
   logic rsp_valid_ff, rsp_valid_in;

   logic [IDX_W-1:0] last_idx;
   logic [31:0] dec_cnt;
   entry_type new_entry;

   assign last_idx  = IDX_W'(count_ff - CNT_W'(1));
   assign dec_cnt   = hit_ff.cnt - 32'd1;
   assign new_entry = '{addr: req_ff.lock_addr, stack: req_ff.stack_ref,
                        is_wr: req_ff.is_write, cnt: 32'd1, stamp: stamp_ff};

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // memory: one write port, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
      rd_data_ff <= mem[rd_idx];
   end

   // state register and work registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pend_ff      <= 1'b0;
         count_ff     <= '0;
         stamp_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         count_ff     <= count_in;
         stamp_ff     <= stamp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff    <= req_in;
      iss_ff    <= iss_in;
      pidx_ff   <= pidx_in;
      found_ff  <= found_in;
      pos_ff    <= pos_in;
      hit_ff    <= hit_in;
      best_ff   <= best_in;
      victim_ff <= victim_in;
      last_ff   <= last_in;
      res_ff    <= res_in;
      rsp_ff    <= rsp_in;
   end

   // next state and datapath
   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      iss_in       = iss_ff;
      pend_in      = pend_ff;
      pidx_in      = pidx_ff;
      found_in     = found_ff;
      pos_in       = pos_ff;
      hit_in       = hit_ff;
      best_in      = best_ff;
      victim_in    = victim_ff;
      last_in      = last_ff;
      count_in     = count_ff;
      stamp_in     = stamp_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      rd_idx       = '0;
      wr_en        = 1'b0;
      wr_idx       = '0;
      wr_data      = new_entry;

      // response register drains independently
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            rd_idx = req_data.read_index[IDX_W-1:0];
            if (req_valid) begin
               req_in    = req_data;
               res_in    = '0;
               iss_in    = '0;
               pend_in   = 1'b0;
               found_in  = 1'b0;
               best_in   = STAMP_MAX;
               victim_in = '0;
               case (req_data.opcode)
                  OP_ADD, OP_DEL: begin
                     state_in = S_SCAN;
                  end
                  OP_READ: begin
                     if (CNT_W'(req_data.read_index) >= count_ff) begin
                        res_in.status = ST_RANGE;
                        state_in = S_RESP;
                     end else begin
                        state_in = S_READ;
                     end
                  end
                  default: begin
                     state_in = S_RESP;
                  end
               endcase
            end
         end

         // walk the table: issue one read per cycle, check the one returned
         S_SCAN: begin
            rd_idx  = iss_ff[IDX_W-1:0];
            pend_in = (iss_ff < count_ff);
            pidx_in = iss_ff[IDX_W-1:0];
            if (iss_ff < count_ff) begin
               iss_in = iss_ff + CNT_W'(1);
            end
            if (pend_ff) begin
               if ((rd_data_ff.addr == req_ff.lock_addr) && !found_ff) begin
                  found_in = 1'b1;
                  pos_in   = pidx_ff;
                  hit_in   = rd_data_ff;
               end
               if (rd_data_ff.stamp < best_ff) begin
                  best_in   = rd_data_ff.stamp;
                  victim_in = pidx_ff;
               end
               if (pidx_ff == last_idx) begin
                  last_in = rd_data_ff;
               end
            end
            if ((iss_ff == count_ff) && !pend_ff) begin
               state_in = S_UPDATE;
            end
         end

         // write back the modified entry, append a new one, or move the last entry into a slot
         S_UPDATE: begin
            state_in = S_RESP;
            case (req_ff.opcode)
               OP_ADD: begin
                  if (found_ff) begin
                     wr_en         = 1'b1;
                     wr_idx        = pos_ff;
                     wr_data       = hit_ff;
                     wr_data.cnt   = hit_ff.cnt + 32'd1;
                     wr_data.stamp = stamp_ff;
                     stamp_in      = stamp_ff + 32'd1;
                  end else if (count_ff < CNT_W'(ENTRIES)) begin
                     wr_en    = 1'b1;
                     wr_idx   = count_ff[IDX_W-1:0];
                     count_in = count_ff + CNT_W'(1);
                     stamp_in = stamp_ff + 32'd1;
                  end else begin
                     // table full: oldest slot takes the last entry
                     wr_en    = 1'b1;
                     wr_idx   = victim_ff;
                     wr_data  = last_ff;
                     state_in = S_APPEND;
                  end
               end
               OP_DEL: begin
                  if (!found_ff) begin
                     res_in.status = ST_ABSENT;
                  end else if (req_ff.destroy || (dec_cnt == 32'd0)) begin
                     wr_en    = 1'b1;
                     wr_idx   = pos_ff;
                     wr_data  = last_ff;
                     count_in = count_ff - CNT_W'(1);
                  end else begin
                     wr_en       = 1'b1;
                     wr_idx      = pos_ff;
                     wr_data     = hit_ff;
                     wr_data.cnt = dec_cnt;
                  end
               end
               default: begin
               end
            endcase
         end

         // new entry goes into the last slot after an eviction
         S_APPEND: begin
            wr_en    = 1'b1;
            wr_idx   = last_idx;
            stamp_in = stamp_ff + 32'd1;
            state_in = S_RESP;
         end

         // read data is back
         S_READ: begin
            res_in.out_addr      = rd_data_ff.addr;
            res_in.out_stack_ref = rd_data_ff.stack;
            res_in.out_is_write  = rd_data_ff.is_wr;
            res_in.out_count     = rd_data_ff.cnt;
            res_in.out_stamp     = rd_data_ff.stamp;
            state_in = S_RESP;
         end

         // hand the result to the output register when it is free
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in          = res_ff;
               rsp_in.set_size = 5'(count_ff);
               rsp_valid_in    = 1'b1;
               state_in        = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(ENTRIES))
      else $error("entry count above table size");

   a_write_state: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == S_UPDATE || state_ff == S_APPEND))
      else $error("memory written outside update");

   a_pend_scan: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (state_ff == S_SCAN))
      else $error("read pending outside search");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff != S_IDLE))
      else $error("request accepted but block stayed idle");

endmodule

// ===== test/lock_table_checker.sv =====
`timescale 1ns / 1ps
module lock_table_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  rlst_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  rlst_pkg::rsp_type rsp_data,
   output int                fail_count,
   output int                pending
);
   import rlst_pkg::*;

   // shadow copy of the lock table
   logic [63:0] slot_addr  [ENTRIES];
   logic [31:0] slot_stack [ENTRIES];
   logic        slot_write [ENTRIES];
   logic [31:0] slot_count [ENTRIES];
   logic [31:0] slot_stamp [ENTRIES];
   int          held;
   logic [31:0] stamp_next;

   rsp_type     expected_rsp_q [$];
   int          errors;

   initial begin
      fail_count = 0;
      pending    = 0;
      errors     = 0;
      held       = 0;
      stamp_next = '0;
   end

   // move the tail entry into the freed slot
   function automatic void drop_entry(int pos);
      int tail;
      tail = held - 1;
      slot_addr[pos]  = slot_addr[tail];
      slot_stack[pos] = slot_stack[tail];
      slot_write[pos] = slot_write[tail];
      slot_count[pos] = slot_count[tail];
      slot_stamp[pos] = slot_stamp[tail];
      held = tail;
   endfunction

   // first matching slot in slot order, -1 when absent
   function automatic int find_entry(logic [63:0] addr);
      for (int i = 0; i < held; i++) begin
         if (slot_addr[i] == addr) return i;
      end
      return -1;
   endfunction

   // apply one request to the shadow table and build its response
   function automatic rsp_type predict_lock_op(req_type r);
      rsp_type     o;
      int          pos;
      int          victim;
      logic [31:0] best;
      o = '0;
      case (r.opcode)
         OP_ADD: begin
            pos = find_entry(r.lock_addr);
            if (pos >= 0) begin
               slot_count[pos] = slot_count[pos] + 32'd1;
               slot_stamp[pos] = stamp_next;
               stamp_next = stamp_next + 32'd1;
            end else begin
               // full table: evict the lowest slot holding the smallest stamp
               if (held >= ENTRIES) begin
                  best   = STAMP_MAX;
                  victim = 0;
                  for (int i = 0; i < ENTRIES; i++) begin
                     if (slot_stamp[i] < best) begin
                        best   = slot_stamp[i];
                        victim = i;
                     end
                  end
                  drop_entry(victim);
               end
               slot_addr[held]  = r.lock_addr;
               slot_stack[held] = r.stack_ref;
               slot_write[held] = r.is_write;
               slot_stamp[held] = stamp_next;
               slot_count[held] = 32'd1;
               stamp_next = stamp_next + 32'd1;
               held = held + 1;
            end
         end
         OP_DEL: begin
            pos = find_entry(r.lock_addr);
            if (pos < 0) begin
               o.status = ST_ABSENT;
            end else begin
               slot_count[pos] = slot_count[pos] - 32'd1;
               if (r.destroy || slot_count[pos] == 32'd0) drop_entry(pos);
            end
         end
         OP_READ: begin
            if (int'(r.read_index) >= held) begin
               o.status = ST_RANGE;
            end else begin
               o.out_addr      = slot_addr[r.read_index];
               o.out_stack_ref = slot_stack[r.read_index];
               o.out_is_write  = slot_write[r.read_index];
               o.out_count     = slot_count[r.read_index];
               o.out_stamp     = slot_stamp[r.read_index];
            end
         end
         default: ;
      endcase
      o.set_size = 5'(held);
      return o;
   endfunction

   function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         errors++;
      end
   endfunction

   // watch both channels at each rising edge
   always @(posedge clock) begin
      rsp_type exp_rsp;
      if (reset) begin
         held       = 0;
         stamp_next = '0;
         expected_rsp_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp_q.size() == 0) begin
               $error("response with no request waiting");
               errors++;
            end else begin
               exp_rsp = expected_rsp_q.pop_front();
               check_field("status", exp_rsp.status, rsp_data.status);
               check_field("out_addr", exp_rsp.out_addr, rsp_data.out_addr);
               check_field("out_stack_ref", exp_rsp.out_stack_ref, rsp_data.out_stack_ref);
               check_field("out_is_write", exp_rsp.out_is_write, rsp_data.out_is_write);
               check_field("out_count", exp_rsp.out_count, rsp_data.out_count);
               check_field("out_stamp", exp_rsp.out_stamp, rsp_data.out_stamp);
               check_field("set_size", exp_rsp.set_size, rsp_data.set_size);
            end
         end
         if (req_valid && req_ready) expected_rsp_q.push_back(predict_lock_op(req_data));
      end
      fail_count <= errors;
      pending    <= expected_rsp_q.size();
   end

endmodule

// ===== test/refcounted_lock_set_table_top_tb.sv =====
`timescale 1ns / 1ps
module refcounted_lock_set_table_top_tb;
   import rlst_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 40;
   localparam int PHASE_ITEMS  = 225;
   localparam int POOL_MAX     = 20;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   int fail_count;
   int pending;
   int cycle_count = 0;
   int idle_pct;
   int stall_pct;
   int pool_used;

   logic [63:0] addr_pool [POOL_MAX];

   refcounted_lock_set_table_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   lock_table_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .fail_count (fail_count),
      .pending    (pending)
   );

   // clock
   initial clock = 1'b0;
   always #10 clock = ~clock;

   // receiver stalls
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("refcounted_lock_set_table_top_tb NOT OK");
         $finish;
      end
   end

   function automatic req_type make_req(logic [1:0] op, logic [63:0] addr, logic [31:0] stack,
                                        logic wr, logic dstr, logic [3:0] idx);
      req_type r;
      r.opcode     = op;
      r.lock_addr  = addr;
      r.stack_ref  = stack;
      r.is_write   = wr;
      r.destroy    = dstr;
      r.read_index = idx;
      return r;
   endfunction

   // offer one request, with an optional idle gap before it
   task automatic send_lock_request(input req_type r);
      if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      req_data  <= r;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // mostly adds and deletes on a small address pool, some noise
   task automatic send_random_item();
      req_type r;
      int      pick;
      r = make_req(2'($urandom_range(3)), {$urandom, $urandom}, $urandom,
                   1'($urandom_range(1)), ($urandom_range(99) < 20),
                   4'($urandom_range(15)));
      pick = $urandom_range(99);
      if (pick < 40) begin
         r.opcode    = OP_ADD;
         r.lock_addr = addr_pool[$urandom_range(pool_used - 1)];
      end else if (pick < 65) begin
         r.opcode    = OP_DEL;
         r.lock_addr = addr_pool[$urandom_range(pool_used - 1)];
      end else if (pick < 70) begin
         r.opcode = OP_DEL;
      end else if (pick < 95) begin
         r.opcode = OP_READ;
      end else begin
         r.opcode = OP_NONE;
      end
      send_lock_request(r);
   endtask

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      rsp_ready = 1'b0;
      idle_pct  = 0;
      stall_pct = 0;
      pool_used = POOL_MAX;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // empty table: out-of-range read, absent delete, unused opcode
      send_lock_request(make_req(OP_READ, '0, '0, 1'b0, 1'b0, 4'd0));
      send_lock_request(make_req(OP_DEL, 64'h1234, '0, 1'b0, 1'b0, 4'd0));
      send_lock_request(make_req(OP_NONE, '1, '1, 1'b1, 1'b1, 4'hF));
      // field extremes, a repeated add and both delete flavors
      send_lock_request(make_req(OP_ADD, '0, '0, 1'b0, 1'b0, 4'd0));
      send_lock_request(make_req(OP_ADD, '1, '1, 1'b1, 1'b0, 4'd0));
      send_lock_request(make_req(OP_ADD, '1, 32'h5A5A_5A5A, 1'b0, 1'b0, 4'd0));
      send_lock_request(make_req(OP_READ, '0, '0, 1'b0, 1'b0, 4'd1));
      send_lock_request(make_req(OP_DEL, '1, '0, 1'b0, 1'b1, 4'd0));
      send_lock_request(make_req(OP_DEL, '0, '0, 1'b0, 1'b0, 4'd0));
      // fill the table, then one more add evicts the oldest entry
      for (int i = 0; i <= ENTRIES; i++) begin
         send_lock_request(make_req(OP_ADD, {$urandom, 32'(i)}, $urandom,
                                    1'($urandom_range(1)), 1'b0, 4'd0));
      end
      send_lock_request(make_req(OP_READ, '0, '0, 1'b0, 1'b0, 4'hF));

      // random phases with different idle and stall mixes
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 53; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 53; end
            default: begin idle_pct = 34; stall_pct = 34; end
         endcase
         pool_used = $urandom_range(6, POOL_MAX);
         for (int i = 0; i < POOL_MAX; i++) addr_pool[i] = {$urandom, $urandom};
         repeat (PHASE_ITEMS) send_random_item();
      end
      req_valid <= 1'b0;

      // drain outstanding responses
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("refcounted_lock_set_table_top_tb OK");
      end else begin
         $display("refcounted_lock_set_table_top_tb NOT OK");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hdl/rlst_pkg.sv
hdl/refcounted_lock_set_table_top.sv
test/lock_table_checker.sv
test/refcounted_lock_set_table_top_tb.sv
